// ===== rtl/mfap_pkg.sv =====
// Shared types, constants and codes for the augmenting-path maximum flow block.
`timescale 1ns / 1ps
package mfap_pkg;

	localparam int NODE_W        = 6;
	localparam int CAPIN_W       = 16;
	localparam int RES_W         = 17;
	localparam int FLOW_W        = 22;
	localparam int CMP_W         = 9;
	localparam int CFG_IDX_W     = 2;
	localparam int DEF_MAX_NODES = 64;
	localparam int DEF_CAP_WIDTH = 16;

	localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NODE_COUNT  = 2'd0,
		CFG_SOURCE_NODE = 2'd1,
		CFG_SINK_NODE   = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_SOLVE = 1'b1
	} func_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BFS_INIT,
		ST_Q_RD,
		ST_Q_WAIT,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_BN_PRD,
		ST_BN_PWAIT,
		ST_BN_RRD,
		ST_BN_RCHK,
		ST_UP_PRD,
		ST_UP_PWAIT,
		ST_UP_FRD,
		ST_UP_FWR,
		ST_UP_BRD,
		ST_UP_BWR,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/max_flow_augmenting_path.sv =====
// A solve with a valid source and sink repeats breadth-first searches over the matrix,
// taking nodes from the queue and scanning their entries, then walks the path edges for the
// bottleneck and again for the update; then max_flow is delivered and the matrix cleared.
// One load per cycle while idle; requests are stalled during a solve and the clearing.
// Reset: asynchronous, active low; the matrix is cleared before a request is taken, while
// configuration writes are taken at any time.
`timescale 1ns / 1ps
module max_flow_augmenting_path
	import mfap_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int CAP_WIDTH = DEF_CAP_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic [NODE_W-1:0]    from_node,
	input  logic [NODE_W-1:0]    to_node,
	input  logic [CAPIN_W-1:0]   edge_capacity,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [FLOW_W-1:0]    max_flow,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NODE_W-1:0]    cfg_data
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int MA = 2 * NW;
	localparam int CW = (CAP_WIDTH < CAPIN_W) ? CAP_WIDTH : CAPIN_W;
	localparam logic [CAPIN_W-1:0] CAP_MASK = CAPIN_W'((64'd1 << CW) - 64'd1);
	localparam logic [CMP_W-1:0] NODE_LIM = CMP_W'(MAX_NODES - 1);

	state_t state_q, state_d;

	logic [NODE_W-1:0]    node_count_q, source_q, sink_q;
	logic [MA-1:0]        clr_q;
	logic                 out_valid_q;
	logic [FLOW_W-1:0]    out_q;
	logic [FLOW_W-1:0]    flow_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [NW:0]          head_q, tail_q;
	logic [NW-1:0]        u_q, v_q, pv_q, pu_q;
	logic [RES_W-1:0]     bottle_q;

	logic [CMP_W-1:0] nc9, n_eff9, src9, dst9;
	logic [NW-1:0]    n_eff, src, dst;
	logic             cfg_ok, load_ok, in_acc, out_free;
	logic [FLOW_W:0]  flow_sum;

	logic             m_we;
	logic [MA-1:0]    m_waddr, m_raddr;
	logic [RES_W-1:0] m_wdata, m_rdata;
	logic             p_we;
	logic [NW-1:0]    p_raddr;
	logic [NW-1:0]    p_rdata;
	logic             q_we;
	logic [NW-1:0]    q_waddr, q_wdata, q_raddr, q_rdata;
	logic             edge_hit;

	// Node count above the largest node index behaves as that index.
	assign nc9    = CMP_W'(node_count_q);
	assign n_eff9 = (nc9 > NODE_LIM) ? NODE_LIM : nc9;
	assign n_eff  = n_eff9[NW-1:0];
	assign src9   = CMP_W'(source_q);
	assign dst9   = CMP_W'(sink_q);
	assign src    = NW'(source_q);
	assign dst    = NW'(sink_q);
	assign cfg_ok = (src9 != '0) && (src9 <= n_eff9) && (dst9 != '0) && (dst9 <= n_eff9);
	assign load_ok = (from_node != '0) && (to_node != '0)
		&& (CMP_W'(from_node) <= NODE_LIM) && (CMP_W'(to_node) <= NODE_LIM);

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign edge_hit = !visited_q[v_q] && (m_rdata != '0);
	assign flow_sum = {1'b0, flow_q} + (FLOW_W + 1)'(bottle_q);

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign max_flow  = out_q;

	mfap_ram #(.DEPTH(MAX_NODES * MAX_NODES), .AW(MA), .DW(RES_W)) u_mat (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	mfap_ram #(.DEPTH(MAX_NODES), .AW(NW), .DW(NW)) u_pred (
		.clk(clk), .we(p_we), .waddr(v_q), .wdata(u_q),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	mfap_ram #(.DEPTH(MAX_NODES), .AW(NW), .DW(NW)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc && (func == FUNC_SOLVE)) state_d = cfg_ok ? ST_BFS_INIT : ST_DONE;
			end
			ST_BFS_INIT: state_d = ST_Q_RD;
			ST_Q_RD: state_d = (head_q == tail_q) ? ST_DONE : ST_Q_WAIT;
			ST_Q_WAIT: state_d = ST_SCAN_RD;
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (edge_hit && (v_q == dst)) state_d = ST_BN_PRD;
				else if (v_q == n_eff) state_d = ST_Q_RD;
				else state_d = ST_SCAN_RD;
			end
			ST_BN_PRD: state_d = (pv_q == src) ? ST_UP_PRD : ST_BN_PWAIT;
			ST_BN_PWAIT: state_d = ST_BN_RRD;
			ST_BN_RRD: state_d = ST_BN_RCHK;
			ST_BN_RCHK: state_d = ST_BN_PRD;
			ST_UP_PRD: state_d = (pv_q == src) ? ST_BFS_INIT : ST_UP_PWAIT;
			ST_UP_PWAIT: state_d = ST_UP_FRD;
			ST_UP_FRD: state_d = ST_UP_FWR;
			ST_UP_FWR: state_d = ST_UP_BRD;
			ST_UP_BRD: state_d = ST_UP_BWR;
			ST_UP_BWR: state_d = ST_UP_PRD;
			ST_DONE: begin
				if (out_free) state_d = ST_CLEAR;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		m_we     = 1'b0;
		m_waddr  = {u_q, v_q};
		m_wdata  = '0;
		m_raddr  = {u_q, v_q};
		p_we     = 1'b0;
		p_raddr  = pv_q;
		q_we     = 1'b0;
		q_waddr  = tail_q[NW-1:0];
		q_wdata  = v_q;
		q_raddr  = head_q[NW-1:0];
		case (state_q)
			ST_CLEAR: begin
				m_we    = 1'b1;
				m_waddr = clr_q;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				m_we     = in_acc && (func == FUNC_LOAD) && load_ok;
				m_waddr  = {NW'(from_node), NW'(to_node)};
				m_wdata  = RES_W'(edge_capacity & CAP_MASK);
			end
			ST_BFS_INIT: begin
				q_we    = 1'b1;
				q_waddr = '0;
				q_wdata = src;
			end
			ST_SCAN_CHK: begin
				p_we = edge_hit;
				q_we = edge_hit && (v_q != dst) && (tail_q < (NW + 1)'(MAX_NODES));
			end
			ST_BN_RRD, ST_UP_FRD: m_raddr = {pu_q, pv_q};
			ST_UP_FWR: begin
				m_we    = 1'b1;
				m_waddr = {pu_q, pv_q};
				m_wdata = m_rdata - bottle_q;
			end
			ST_UP_BRD: m_raddr = {pv_q, pu_q};
			ST_UP_BWR: begin
				m_we    = 1'b1;
				m_waddr = {pv_q, pu_q};
				m_wdata = m_rdata + bottle_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
			flow_q       <= '0;
			node_count_q <= NODE_W'(63);
			source_q     <= NODE_W'(1);
			sink_q       <= NODE_W'(2);
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_NODE_COUNT:  node_count_q <= cfg_data;
					CFG_SOURCE_NODE: source_q     <= cfg_data;
					CFG_SINK_NODE:   sink_q       <= cfg_data;
					default: begin
					end
				endcase
			end
			if ((state_q == ST_DONE) && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + MA'(1);
				ST_UP_PRD: begin
					if (pv_q == src) begin
						flow_q <= (flow_sum > (FLOW_W + 1)'(FLOW_MAX)) ? FLOW_MAX
							: flow_sum[FLOW_W-1:0];
					end
				end
				ST_DONE: begin
					if (out_free) begin
						flow_q      <= '0;
						clr_q       <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_BFS_INIT: begin
				visited_q      <= MAX_NODES'(1) << src;
				head_q         <= '0;
				tail_q         <= (NW + 1)'(1);
			end
			ST_Q_RD: head_q <= head_q + (NW + 1)'(1);
			ST_Q_WAIT: begin
				u_q <= q_rdata;
				v_q <= NW'(1);
			end
			ST_SCAN_CHK: begin
				if (edge_hit && (v_q == dst)) begin
					pv_q     <= dst;
					bottle_q <= '1;
				end else begin
					if (edge_hit) begin
						visited_q[v_q] <= 1'b1;
						if (tail_q < (NW + 1)'(MAX_NODES)) tail_q <= tail_q + (NW + 1)'(1);
					end
					v_q <= v_q + NW'(1);
				end
			end
			ST_BN_PRD: begin
				if (pv_q == src) pv_q <= dst;
			end
			ST_BN_PWAIT, ST_UP_PWAIT: pu_q <= p_rdata;
			ST_BN_RCHK: begin
				if (m_rdata < bottle_q) bottle_q <= m_rdata;
				pv_q <= pu_q;
			end
			ST_UP_BWR: pv_q <= pu_q;
			ST_DONE: begin
				if (out_free) out_q <= flow_q;
			end
			default: begin
			end
		endcase
	end

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the completion state");

	a_solve_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (func == FUNC_SOLVE)) |=> in_stall)
		else $error("request taken while a solve is under way");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_RD || state_q == ST_SCAN_CHK) |-> (head_q <= tail_q))
		else $error("search queue read beyond its fill");

	a_bottle_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP_FWR) |-> (bottle_q != '0))
		else $error("augmenting with a zero bottleneck");

endmodule

// ===== rtl/mfap_ram.sv =====
// Simple dual-port memory with one write port and one registered read port.
`timescale 1ns / 1ps
module mfap_ram
	import mfap_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_NODES,
	parameter int AW    = $clog2(DEF_MAX_NODES),
	parameter int DW    = NODE_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the augmenting-path maximum flow block.
`timescale 1ns / 1ps
module tb;
	import mfap_pkg::*;

	localparam int WDOG_LIMIT = 2000000;
	localparam int LONG_HOLD  = 20000;

	typedef struct {
		func_t               fn;
		logic [NODE_W-1:0]   src;
		logic [NODE_W-1:0]   dst;
		logic [CAPIN_W-1:0]  cap;
		bit                  has_flow;
		logic [FLOW_W-1:0]   flow;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 func = FUNC_LOAD;
	logic [NODE_W-1:0]    from_node = '0;
	logic [NODE_W-1:0]    to_node = '0;
	logic [CAPIN_W-1:0]   edge_capacity = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [FLOW_W-1:0]    max_flow;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_NODE_COUNT;
	logic [NODE_W-1:0]    cfg_data = '0;

	max_flow_augmenting_path dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the block: residual matrix, search scratch and registers.
	logic [RES_W-1:0]  resid [64][64];
	bit                seen [64];
	logic [NODE_W-1:0] came_from [64];
	logic [NODE_W-1:0] node_lim = 6'd63, flow_src = 6'd1, flow_dst = 6'd2;

	logic [FLOW_W-1:0] flow_q [$];
	int errors = 0, n_loads = 0, n_solves = 0, n_flows = 0, n_cfg = 0;
	int hold_cycles = 0;
	bit quiet = 1'b0;
	bit acc_seen;

	function automatic bit find_path(int n);
		logic [NODE_W-1:0] fifo [64];
		int head, tail, u;
		head = 0;
		tail = 0;
		foreach (seen[i]) begin
			seen[i] = 1'b0;
			came_from[i] = '0;
		end
		fifo[tail++] = flow_src;
		seen[flow_src] = 1'b1;
		while (head < tail) begin
			u = fifo[head++];
			for (int v = 1; v <= n; v++) begin
				if (!seen[v] && resid[u][v] != 0) begin
					came_from[v] = u[NODE_W-1:0];
					if (v == flow_dst)
						return 1'b1;
					seen[v] = 1'b1;
					if (tail < 64)
						fifo[tail++] = v[NODE_W-1:0];
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [FLOW_W-1:0] solve_flow();
		int n, v, u, steps;
		longint total, bottle;
		n = node_lim;
		total = 0;
		if (flow_src == 0 || flow_src > n || flow_dst == 0 || flow_dst > n)
			return '0;
		while (find_path(n)) begin
			bottle = 64'hFFFF_FFFF;
			v = flow_dst;
			for (steps = 0; v != flow_src && steps < 64; steps++) begin
				u = came_from[v];
				if (resid[u][v] < bottle)
					bottle = resid[u][v];
				v = u;
			end
			v = flow_dst;
			for (steps = 0; v != flow_src && steps < 64; steps++) begin
				u = came_from[v];
				resid[u][v] = resid[u][v] - bottle[RES_W-1:0];
				resid[v][u] = resid[v][u] + bottle[RES_W-1:0];
				v = u;
			end
			total += bottle;
			if (total > FLOW_MAX)
				total = FLOW_MAX;
		end
		return total[FLOW_W-1:0];
	endfunction

	function automatic void clear_matrix();
		foreach (resid[a, b])
			resid[a][b] = '0;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Send one request; the shadow is updated at the edge that takes it.
	task automatic send(func_t fn, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
			logic [CAPIN_W-1:0] c, bit typed, logic [FLOW_W-1:0] want);
		logic [FLOW_W-1:0] flow;
		func = fn;
		from_node = a;
		to_node = b;
		edge_capacity = c;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		if (fn == FUNC_LOAD) begin
			n_loads++;
			if (a != 0 && b != 0)
				resid[a][b] = {1'b0, c};
		end else begin
			n_solves++;
			flow = solve_flow();
			if (typed && flow != want) begin
				$error("typed flow %0d disagrees with shadow %0d", want, flow);
				errors++;
			end
			flow_q.insert(flow_q.size(), typed ? want : flow);
			clear_matrix();
		end
		@(negedge clk);
		repeat (gap_len()) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b0;
	endtask

	task automatic load(int a, int b, int c);
		send(FUNC_LOAD, a[NODE_W-1:0], b[NODE_W-1:0], c[CAPIN_W-1:0], 1'b0, '0);
	endtask

	task automatic run_solve();
		send(FUNC_SOLVE, '0, '0, '0, 1'b0, '0);
	endtask

	// Waits until every flow has come back before writing.
	task automatic write_reg(cfg_idx_t idx, int val);
		while (flow_q.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		cfg_index = idx;
		cfg_data = val[NODE_W-1:0];
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		n_cfg++;
		case (idx)
			CFG_NODE_COUNT:  node_lim = val[NODE_W-1:0];
			CFG_SOURCE_NODE: flow_src = val[NODE_W-1:0];
			CFG_SINK_NODE:   flow_dst = val[NODE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic setup(int n, int s, int d);
		write_reg(CFG_NODE_COUNT, n);
		write_reg(CFG_SOURCE_NODE, s);
		write_reg(CFG_SINK_NODE, d);
	endtask

	// Receiver: random stalls, plus one long hold-off when asked for.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (quiet)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 99) < 25);
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (flow_q.size() == 0) begin
				$error("max_flow: unexpected result %0d", max_flow);
				errors++;
			end else begin
				if (max_flow !== flow_q[0]) begin
					$error("max_flow: expected %0d, actual %0d", flow_q[0], max_flow);
					errors++;
				end
				void'(flow_q.pop_front());
				n_flows++;
			end
		end
	end

	// Watchdog over cycles in which no channel moves anything.
	int idle_cycles = 0;
	always @(posedge clk) begin
		acc_seen = (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready);
		idle_cycles <= acc_seen ? 0 : idle_cycles + 1;
		if (idle_cycles > WDOG_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	row_t rows [] = '{
		'{FUNC_SOLVE, 6'd0,  6'd0,  16'd0,     1'b1, 22'd0},
		'{FUNC_LOAD,  6'd1,  6'd2,  16'hFFFF,  1'b0, 22'd0},
		'{FUNC_SOLVE, 6'd0,  6'd0,  16'd0,     1'b1, 22'd65535},
		'{FUNC_LOAD,  6'd0,  6'd2,  16'd7,     1'b0, 22'd0},
		'{FUNC_LOAD,  6'd2,  6'd0,  16'd7,     1'b0, 22'd0},
		'{FUNC_LOAD,  6'd1,  6'd1,  16'd9,     1'b0, 22'd0},
		'{FUNC_SOLVE, 6'd0,  6'd0,  16'd0,     1'b1, 22'd0},
		'{FUNC_LOAD,  6'd1,  6'd3,  16'hFFFF,  1'b0, 22'd0},
		'{FUNC_LOAD,  6'd3,  6'd2,  16'd1,     1'b0, 22'd0},
		'{FUNC_LOAD,  6'd1,  6'd2,  16'd4,     1'b0, 22'd0},
		'{FUNC_LOAD,  6'd1,  6'd2,  16'd6,     1'b0, 22'd0},
		'{FUNC_SOLVE, 6'd0,  6'd0,  16'd0,     1'b0, 22'd0},
		'{FUNC_LOAD,  6'd1,  6'd63, 16'hFFFF,  1'b0, 22'd0},
		'{FUNC_LOAD,  6'd63, 6'd2,  16'd100,   1'b0, 22'd0},
		'{FUNC_LOAD,  6'd63, 6'd63, 16'd0,     1'b0, 22'd0},
		'{FUNC_LOAD,  6'd1,  6'd42, 16'h5555,  1'b0, 22'd0},
		'{FUNC_LOAD,  6'd42, 6'd2,  16'hAAAA,  1'b0, 22'd0},
		'{FUNC_SOLVE, 6'd0,  6'd0,  16'd0,     1'b0, 22'd0}
	};

	initial begin
		int nc, s, d, edges, sent;
		clear_matrix();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send(rows[i].fn, rows[i].src, rows[i].dst, rows[i].cap,
				rows[i].has_flow, rows[i].flow);

		// Edges beyond the node count, source equal to sink, ranges out of bounds.
		setup(3, 1, 2);
		load(1, 5, 50); load(5, 2, 50); load(1, 3, 8); load(3, 2, 9);
		run_solve();
		write_reg(CFG_UNUSED, 17);
		setup(63, 2, 2);
		load(2, 3, 10); load(3, 2, 10); run_solve();
		setup(2, 0, 2);
		load(1, 2, 10); run_solve();
		setup(4, 1, 9);
		load(1, 2, 10); run_solve();
		setup(0, 1, 2);
		load(1, 2, 10); run_solve();

		// Random part: long hold-off first, then phases of random graphs, some out of range.
		while (flow_q.size() != 0)
			@(negedge clk);
		hold_cycles = LONG_HOLD;
		sent = 0;
		while (sent < 1500) begin
			quiet = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 9))
				0:       nc = 63;
				1:       nc = $urandom_range(0, 63);
				default: nc = $urandom_range(2, 8);
			endcase
			s = (nc >= 1 && $urandom_range(0, 9) != 0) ? $urandom_range(1, nc) :
				$urandom_range(0, 63);
			d = (nc >= 1 && $urandom_range(0, 9) != 0) ? $urandom_range(1, nc) :
				$urandom_range(0, 63);
			setup(nc, s, d);
			repeat ($urandom_range(2, 6)) begin
				edges = (nc == 63) ? $urandom_range(20, 80) : $urandom_range(1, 20);
				repeat (edges) begin
					int a, b, c;
					if ($urandom_range(0, 9) == 0) begin
						a = $urandom_range(0, 63);
						b = $urandom_range(0, 63);
					end else begin
						a = $urandom_range(1, (nc > 1) ? nc : 2);
						b = $urandom_range(1, (nc > 1) ? nc : 2);
						if ($urandom_range(0, 3) == 0) a = s;
						if ($urandom_range(0, 3) == 0) b = d;
					end
					case ($urandom_range(0, 7))
						0:       c = 0;
						1:       c = 16'hFFFF;
						2:       c = $urandom_range(1, 15);
						default: c = $urandom_range(0, 65535);
					endcase
					load(a, b, c);
					if (a != 0 && b != 0)
						sent++;
				end
				run_solve();
				sent++;
			end
		end
		quiet = 1'b0;

		while (flow_q.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		$display("Covered %0d edge loads, %0d solves, %0d flows checked, %0d register writes.",
			n_loads, n_solves, n_flows, n_cfg);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
